FILE: hw/rtl/rspd_pkg.sv
// ----------------------------------------------------------------------------
// rspd_pkg
// Shared types, codes and constants of the remote serial packet deframer.
// ----------------------------------------------------------------------------
package rspd_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PLEN_W   = 10;
  localparam int unsigned RIDX_W   = 9;

  localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABORT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PROTO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF   = 3'd4;

  localparam logic [7:0] CH_BREAK  = 8'h03;
  localparam logic [7:0] CH_START  = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_REPEAT = 8'h2A;
  localparam logic [7:0] CH_ESCAPE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] RPT_BIAS  = 8'd29;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_WAIT   = 7'b0000010,
    PH_COLECT = 7'b0000100,
    PH_HEX1   = 7'b0001000,
    PH_HEX2   = 7'b0010000,
    PH_ESC    = 7'b0100000,
    PH_REP    = 7'b1000000
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_RFETCH = 5'b00100,
    S_FILL   = 5'b01000,
    S_OUT    = 5'b10000
  } seq_e;

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/rspd_if.sv
// ----------------------------------------------------------------------------
// rspd_if
// Request channels of the packet deframer: line bytes and reads in, results out.
// ----------------------------------------------------------------------------
interface rspd_in_if import rspd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [7:0]        line_byte;
  logic [RIDX_W-1:0] read_index;

  modport source(output valid, action, line_byte, read_index, input ready);
  modport sink(input valid, action, line_byte, read_index, output ready);
endinterface

interface rspd_out_if import rspd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [7:0]          read_data;
  logic [PLEN_W-1:0]   payload_length;
  logic [7:0]          computed_checksum;
  logic [7:0]          received_checksum;

  modport source(output valid, status, read_data, payload_length, computed_checksum,
                 received_checksum, input ready);
  modport sink(input valid, status, read_data, payload_length, computed_checksum,
               received_checksum, output ready);
endinterface

FILE: hw/rtl/rspd_store.sv
// ----------------------------------------------------------------------------
// rspd_store
// Payload buffer: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rspd_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rsp_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// rsp_packet_deframer_top
// Decodes $payload#xx packets one line byte per request and serves reads of
// the stored payload.
// ----------------------------------------------------------------------------
// One request is handled at a time. A line byte goes straight from
// acceptance to the S_OUT result state. A read passes through S_RDWAIT
// first, because the payload buffer has a registered read port. A
// run-length repeat fetches the last stored byte in S_RFETCH and then
// writes its copies in S_FILL, through the single write port of the
// buffer, and stops with an overflow status when the buffer fills up. Each
// result then waits until it is taken, and the next request is accepted in
// the cycle after that. The buffer needs no clearing after reset.
module rsp_packet_deframer_top import rspd_pkg::*; #(
  parameter int unsigned BUF_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rspd_in_if.sink     in_i,
  rspd_out_if.source  out_o
);

  localparam int unsigned AW   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned WCW  = $clog2(BUF_BYTES + 1);
  localparam int unsigned AIW  = (AW > RIDX_W) ? AW : RIDX_W;
  localparam int unsigned LW   = (WCW > PLEN_W) ? WCW : PLEN_W;

  seq_e                state_q, state_d;
  phase_e              phase_q, phase_d;
  phase_e              ph_cur;
  logic [WCW-1:0]      wc_q, wc_d, wc_cur, wc_m1;
  logic [7:0]          sum_q, sum_d, sum_cur;
  logic [7:0]          rcv_q, rcv_d, rcv_cur;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [7:0]          rdata_q, rdata_d;
  logic [7:0]          fill_q, fill_d;
  logic [7:0]          cnt_q, cnt_d;
  logic                rdok_q, rdok_d;
  logic                we;
  logic [7:0]          wdata;
  logic [AW-1:0]       raddr;
  logic [7:0]          mem_rdata;
  logic [AIW-1:0]      ridx_ext;
  logic [LW-1:0]       wc_ext;
  logic                has_room;
  logic [7:0]          c;

  assign c        = in_i.line_byte;
  assign ridx_ext = AIW'(in_i.read_index);
  assign wc_m1    = wc_q - WCW'(1);
  assign has_room = (wc_q < WCW'(BUF_BYTES));
  assign raddr    = in_i.action ? ridx_ext[AW-1:0] : wc_m1[AW-1:0];

  rspd_store #(
    .DEPTH (BUF_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wc_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    wc_d     = wc_q;
    sum_d    = sum_q;
    rcv_d    = rcv_q;
    status_d = status_q;
    rdata_d  = rdata_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    rdok_d   = rdok_q;
    we       = 1'b0;
    wdata    = c;
    ph_cur   = phase_q;
    wc_cur   = wc_q;
    sum_cur  = sum_q;
    rcv_cur  = rcv_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rdata_d  = '0;
          status_d = ST_BUSY;
          if (in_i.action) begin
            rdok_d  = (32'(in_i.read_index) < 32'(BUF_BYTES));
            state_d = S_RDWAIT;
          end else begin
            state_d = S_OUT;
            if (phase_q == PH_START) begin
              wc_cur  = '0;
              sum_cur = '0;
              rcv_cur = '0;
              ph_cur  = PH_WAIT;
            end
            wc_d    = wc_cur;
            sum_d   = sum_cur;
            rcv_d   = rcv_cur;
            phase_d = ph_cur;
            case (ph_cur)
              PH_WAIT: begin
                if (c == CH_START) begin
                  phase_d = PH_COLECT;
                end else if (c != CH_BREAK && c != CH_PLUS && c != CH_MINUS) begin
                  status_d = ST_ABORT;
                end
              end
              PH_COLECT: begin
                if (c == CH_HASH) begin
                  phase_d = PH_HEX1;
                end else begin
                  sum_d = sum_cur + c;
                  if (c == CH_REPEAT) begin
                    phase_d = PH_REP;
                  end else if (c == CH_ESCAPE) begin
                    phase_d = PH_ESC;
                  end else if (has_room) begin
                    we   = 1'b1;
                    wc_d = wc_cur + WCW'(1);
                  end else begin
                    status_d = ST_OVF;
                  end
                end
              end
              PH_HEX1: begin
                phase_d = PH_HEX2;
                rcv_d   = {rcv_cur[3:0], hex_value(c)};
              end
              PH_HEX2: begin
                phase_d  = PH_START;
                rcv_d    = {rcv_cur[3:0], hex_value(c)};
                status_d = ST_DONE;
              end
              PH_ESC: begin
                phase_d = PH_COLECT;
                sum_d   = sum_cur + c;
                wdata   = c ^ ESC_MASK;
                if (has_room) begin
                  we   = 1'b1;
                  wc_d = wc_cur + WCW'(1);
                end else begin
                  status_d = ST_OVF;
                end
              end
              PH_REP: begin
                phase_d = PH_COLECT;
                sum_d   = sum_cur + c;
                if (wc_cur == '0) begin
                  status_d = ST_PROTO;
                end else if (c > RPT_BIAS) begin
                  cnt_d   = c - RPT_BIAS;
                  state_d = S_RFETCH;
                end
              end
              default: begin
                phase_d = PH_START;
              end
            endcase
          end
        end
      end
      S_RDWAIT: begin
        rdata_d = rdok_q ? mem_rdata : 8'd0;
        state_d = S_OUT;
      end
      S_RFETCH: begin
        fill_d  = mem_rdata;
        state_d = S_FILL;
      end
      S_FILL: begin
        wdata = fill_q;
        if (!has_room) begin
          status_d = ST_OVF;
          state_d  = S_OUT;
        end else begin
          we    = 1'b1;
          wc_d  = wc_q + WCW'(1);
          cnt_d = cnt_q - 8'd1;
          if (cnt_q == 8'd1) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_START;
      wc_q     <= '0;
      sum_q    <= '0;
      rcv_q    <= '0;
      status_q <= ST_BUSY;
      rdok_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      wc_q     <= wc_d;
      sum_q    <= sum_d;
      rcv_q    <= rcv_d;
      status_q <= status_d;
      rdok_q   <= rdok_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    fill_q  <= fill_d;
  end

  assign wc_ext = LW'(wc_q);

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = (state_q == S_OUT);
  assign out_o.status            = status_q;
  assign out_o.read_data         = rdata_q;
  assign out_o.payload_length    = wc_ext[PLEN_W-1:0];
  assign out_o.computed_checksum = sum_q;
  assign out_o.received_checksum = rcv_q;

endmodule

FILE: hw/rtl/rspd_checker.sv
// ----------------------------------------------------------------------------
// rspd_checker
// Port-level checks of the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rspd_checker import rspd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [7:0]          read_data_i,
  input logic [PLEN_W-1:0]   payload_length_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(read_data_i) && $stable(payload_length_i))
    else $error("Result changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request accepted while another is in progress.");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("Ready while a result is pending.");

  a_line_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_BUSY |-> read_data_i == 8'd0)
    else $error("Read data set on a line byte result.");

  a_proto_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_PROTO |-> payload_length_i == '0)
    else $error("Protocol error with a non-empty buffer.");

endmodule

bind rsp_packet_deframer_top rspd_checker u_rspd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .read_data_i      (out_o.read_data),
  .payload_length_i (out_o.payload_length)
);
